### rtl/pnlm_pkg.sv
package pnlm_pkg;

	// Store geometry.
	localparam int MAX_WIDTH      = 64;
	localparam int MAX_HEIGHT     = 64;
	localparam int MAX_CHANNELS   = 3;
	localparam int MAX_HALF_PATCH = 4;

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int SITE_W     = COL_W + ROW_W;
	localparam int SITES      = MAX_WIDTH * MAX_HEIGHT;
	localparam int CH_W       = 2;
	localparam int HP_W       = 3;
	localparam int DIM_W      = 7;
	localparam int PATCH_SPAN = 2 * MAX_HALF_PATCH + 1;
	localparam int SPAN_W     = $clog2(PATCH_SPAN);
	localparam int WT_DEPTH   = PATCH_SPAN * PATCH_SPAN;
	localparam int WT_AW      = $clog2(WT_DEPTH);

	// Arithmetic widths.
	localparam int PIX_W   = 16;
	localparam int CONF_W  = 17;
	localparam int FLD_W   = 13;
	localparam int W_W     = 32;
	localparam int PROD_W  = PIX_W + W_W;
	localparam int WSUM_W  = W_W + $clog2(WT_DEPTH);
	localparam int CSUM_W  = PROD_W + $clog2(WT_DEPTH);
	localparam int NUM_W   = CSUM_W + 1;
	localparam int SQ_W    = 2 * PIX_W;
	localparam int TOT_W   = 48;
	localparam int CONF_ONE = 65536;
	localparam logic [TOT_W-1:0] TOT_MAX = '1;

	localparam int APB_AW = 5;

	typedef enum logic [2:0] {
		CMD_LOAD_PIX    = 3'd0,
		CMD_LOAD_FIELD  = 3'd1,
		CMD_LOAD_MASK   = 3'd2,
		CMD_LOAD_WEIGHT = 3'd3,
		CMD_START       = 3'd4,
		CMD_READ        = 3'd5
	} cmd_code_t;

	typedef enum logic {
		RES_PIXEL = 1'b0,
		RES_PASS  = 1'b1
	} res_kind_t;

	typedef enum logic [2:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_CHANS    = 3'd2,
		REG_HPX      = 3'd3,
		REG_HPY      = 3'd4,
		REG_USE_CONF = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_PIX, ST_PIX_W, ST_WIN, ST_WIN_W, ST_MUL, ST_ADD,
		ST_CTR, ST_CTR_W, ST_DGO, ST_DIV, ST_WB, ST_TOT, ST_NEXT, ST_DONE
	} state_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [CH_W-1:0]  chans;
		logic [HP_W-1:0]  hpx;
		logic [HP_W-1:0]  hpy;
		logic             use_conf;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        command;
		logic [COL_W-1:0]  pos_x;
		logic [ROW_W-1:0]  pos_y;
		logic [CH_W-1:0]   channel;
		logic [PIX_W-1:0]  pixel_in;
		logic [6:0]        field_x;
		logic [5:0]        field_y;
		logic              in_domain;
		logic [CONF_W-1:0] confidence;
		logic [15:0]       weight_in;
	} item_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic rd_move;
		logic pix_rd;
		logic pix_eval;
		logic win_rd;
		logic win_eval;
		logic mul;
		logic add;
		logic ctr_rd;
		logic ctr_eval;
		logic div_start;
		logic wb;
		logic tot;
		logic next_pix;
		logic done_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic rd_pend;
		logic out_full;
		logic dom_hit;
		logic win_last;
		logic wsum_zero;
		logic div_done;
		logic ch_last;
		logic img_last;
	} stat_t;

endpackage

### rtl/pnlm_if.sv
interface pnlm_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [5:0]  pos_x;
	logic [5:0]  pos_y;
	logic [1:0]  channel;
	logic [15:0] pixel_in;
	logic signed [6:0] field_x;
	logic [5:0]  field_y;
	logic        in_domain;
	logic [16:0] confidence;
	logic [15:0] weight_in;

	modport source(output valid, command, pos_x, pos_y, channel, pixel_in, field_x,
		field_y, in_domain, confidence, weight_in, input ready);
	modport sink(input valid, command, pos_x, pos_y, channel, pixel_in, field_x,
		field_y, in_domain, confidence, weight_in, output ready);
endinterface

interface pnlm_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [15:0] pixel_out;
	logic [47:0] total_change;

	modport source(output valid, result_kind, pixel_out, total_change, input ready);
	modport sink(input valid, result_kind, pixel_out, total_change, output ready);
endinterface

### rtl/patch_nlmeans_inpaint_update_core.sv
// Channel   Dir   Protocol        Payload
// item      in    valid/ready     command, pos_x, pos_y, channel, pixel_in, field_x,
//                                 field_y, in_domain, confidence, weight_in
// result    out   valid/ready     result_kind, pixel_out, total_change
// apb       in    psel/penable    six configuration registers at byte address 4*i
//
// After reset the block sweeps the field and domain stores and takes no beat.
// Load and read beats are taken one per cycle while no readback waits on a full output register;
// a read result leaves through an output register. A start beat holds input off for the whole pass,
// which steps each domain pixel through the shared window loop and then, per channel, the
// bit-serial divider (one quotient bit per cycle), and finally posts the result.
// A stalled result holds the output register; input keeps flowing until a read needs the slot.
module patch_nlmeans_inpaint_update_core (
	input  logic                        clk,
	input  logic                        arst_n,
	pnlm_item_if.sink                   item,
	pnlm_result_if.source               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pnlm_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int DIM_W = pnlm_pkg::DIM_W;
	localparam int HP_W  = pnlm_pkg::HP_W;
	localparam int CH_W  = pnlm_pkg::CH_W;

	pnlm_pkg::cfg_t    cfg_q;
	pnlm_pkg::item_t   item_d;
	pnlm_pkg::cmd_t    cmd;
	pnlm_pkg::stat_t   stat;
	pnlm_pkg::reg_idx_t reg_idx;
	logic              cfg_we;
	logic              item_ready;
	logic              out_kind;

	logic [DIM_W-1:0] wr_dim;
	logic [CH_W-1:0]  wr_ch;
	logic [HP_W-1:0]  wr_hp;

	// The write strobe lands on the access phase; pready never stalls.
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign reg_idx = pnlm_pkg::reg_idx_t'(paddr[pnlm_pkg::APB_AW-1:2]);

	// Each field keeps only its low bits; values out of range are then clamped into range.
	always_comb begin
		wr_dim = pwdata[DIM_W-1:0];
		if (wr_dim == '0) begin
			wr_dim = DIM_W'(1);
		end
		wr_ch = (pwdata[CH_W-1:0] == '0) ? CH_W'(1) :
		        (({1'b0, pwdata[CH_W-1:0]} > (CH_W+1)'(pnlm_pkg::MAX_CHANNELS)) ?
		         CH_W'(pnlm_pkg::MAX_CHANNELS) : pwdata[CH_W-1:0]);
		wr_hp = (pwdata[HP_W-1:0] > HP_W'(pnlm_pkg::MAX_HALF_PATCH)) ?
		        HP_W'(pnlm_pkg::MAX_HALF_PATCH) : pwdata[HP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width    <= DIM_W'(pnlm_pkg::MAX_WIDTH);
			cfg_q.height   <= DIM_W'(pnlm_pkg::MAX_HEIGHT);
			cfg_q.chans    <= CH_W'(pnlm_pkg::MAX_CHANNELS);
			cfg_q.hpx      <= HP_W'(2);
			cfg_q.hpy      <= HP_W'(2);
			cfg_q.use_conf <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx)
				pnlm_pkg::REG_WIDTH: begin
					cfg_q.width <= (wr_dim > DIM_W'(pnlm_pkg::MAX_WIDTH)) ?
					               DIM_W'(pnlm_pkg::MAX_WIDTH) : wr_dim;
				end
				pnlm_pkg::REG_HEIGHT: begin
					cfg_q.height <= (wr_dim > DIM_W'(pnlm_pkg::MAX_HEIGHT)) ?
					                DIM_W'(pnlm_pkg::MAX_HEIGHT) : wr_dim;
				end
				pnlm_pkg::REG_CHANS:    cfg_q.chans    <= wr_ch;
				pnlm_pkg::REG_HPX:      cfg_q.hpx      <= wr_hp;
				pnlm_pkg::REG_HPY:      cfg_q.hpy      <= wr_hp;
				pnlm_pkg::REG_USE_CONF: cfg_q.use_conf <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pnlm_pkg::REG_WIDTH:    prdata = 32'(cfg_q.width);
			pnlm_pkg::REG_HEIGHT:   prdata = 32'(cfg_q.height);
			pnlm_pkg::REG_CHANS:    prdata = 32'(cfg_q.chans);
			pnlm_pkg::REG_HPX:      prdata = 32'(cfg_q.hpx);
			pnlm_pkg::REG_HPY:      prdata = 32'(cfg_q.hpy);
			pnlm_pkg::REG_USE_CONF: prdata = 32'(cfg_q.use_conf);
			default:                prdata = '0;
		endcase
	end

	// Input beat payload gathered into one word for the datapath.
	always_comb begin
		item_d.command    = item.command;
		item_d.pos_x      = item.pos_x;
		item_d.pos_y      = item.pos_y;
		item_d.channel    = item.channel;
		item_d.pixel_in   = item.pixel_in;
		item_d.field_x    = item.field_x;
		item_d.field_y    = item.field_y;
		item_d.in_domain  = item.in_domain;
		item_d.confidence = item.confidence;
		item_d.weight_in  = item.weight_in;
	end

	// The sequencer owns the handshakes and steps the datapath through each pixel.
	pnlm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.start_req  (item.command == pnlm_pkg::CMD_START),
		.out_ready  (result.ready),
		.stat       (stat),
		.item_ready (item_ready),
		.cmd        (cmd)
	);

	// The datapath holds all stores, the accumulators, the divider and the output register.
	pnlm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_d    (item_d),
		.cmd       (cmd),
		.out_ready (result.ready),
		.stat      (stat),
		.out_valid (result.valid),
		.out_kind  (out_kind),
		.out_pixel (result.pixel_out),
		.out_total (result.total_change)
	);

	assign item.ready         = item_ready;
	assign result.result_kind = out_kind;

`ifndef NO_ASSERTIONS
	// A pass never starts while a readback still waits for the output register.
	a_pass_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.win_rd |-> !stat.rd_pend)
		else $error("window read while a readback is pending");

	// The pass result is only posted into a free or draining output register.
	a_done_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done_load |-> (!stat.out_full || result.ready))
		else $error("pass result overwrote a waiting beat");

	// A readback moves only when one was issued.
	a_move_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_move |-> stat.rd_pend)
		else $error("readback moved with nothing pending");

	// Write-back follows the divider finishing.
	a_wb_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |-> $past(stat.div_done))
		else $error("write-back without a finished quotient");
`endif

endmodule

### rtl/pnlm_ram.sv
module pnlm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/pnlm_div.sv
module pnlm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pnlm_pkg::NUM_W-1:0]    num,
	input  logic [pnlm_pkg::WSUM_W-1:0]   den,
	output logic                          done,
	output logic [pnlm_pkg::PIX_W-1:0]    quot
);

	localparam int NW  = pnlm_pkg::NUM_W;
	localparam int QW  = pnlm_pkg::PIX_W;
	localparam int CW  = $clog2(QW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] dsh_q;
	logic [QW-1:0] quot_q;
	logic          ge;

	// One quotient bit per cycle, most significant first.
	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= NW'(den) << (QW - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

### rtl/pnlm_ctrl.sv
module pnlm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                start_req,
	input  logic                out_ready,
	input  pnlm_pkg::stat_t     stat,
	output logic                item_ready,
	output pnlm_pkg::cmd_t      cmd
);

	pnlm_pkg::state_t state_q;
	pnlm_pkg::state_t state_nxt;
	logic             move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pnlm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd        = '0;
		state_nxt  = state_q;
		item_ready = 1'b0;
		move       = stat.rd_pend && (!stat.out_full || out_ready);
		case (state_q)
			pnlm_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_nxt = pnlm_pkg::ST_IDLE;
				end
			end
			pnlm_pkg::ST_IDLE: begin
				cmd.rd_move = move;
				item_ready  = !stat.rd_pend || move;
				cmd.accept  = item_valid && item_ready;
				if (cmd.accept && start_req) begin
					state_nxt = pnlm_pkg::ST_PIX;
				end
			end
			pnlm_pkg::ST_PIX: begin
				cmd.pix_rd = 1'b1;
				state_nxt  = pnlm_pkg::ST_PIX_W;
			end
			pnlm_pkg::ST_PIX_W: begin
				cmd.pix_eval = 1'b1;
				state_nxt    = stat.dom_hit ? pnlm_pkg::ST_WIN : pnlm_pkg::ST_NEXT;
			end
			pnlm_pkg::ST_WIN: begin
				cmd.win_rd = 1'b1;
				state_nxt  = pnlm_pkg::ST_WIN_W;
			end
			pnlm_pkg::ST_WIN_W: begin
				cmd.win_eval = 1'b1;
				state_nxt    = pnlm_pkg::ST_MUL;
			end
			pnlm_pkg::ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = pnlm_pkg::ST_ADD;
			end
			pnlm_pkg::ST_ADD: begin
				cmd.add   = 1'b1;
				state_nxt = stat.win_last ? pnlm_pkg::ST_CTR : pnlm_pkg::ST_WIN;
			end
			pnlm_pkg::ST_CTR: begin
				cmd.ctr_rd = 1'b1;
				state_nxt  = pnlm_pkg::ST_CTR_W;
			end
			pnlm_pkg::ST_CTR_W: begin
				cmd.ctr_eval = 1'b1;
				state_nxt    = stat.wsum_zero ? pnlm_pkg::ST_NEXT : pnlm_pkg::ST_DGO;
			end
			pnlm_pkg::ST_DGO: begin
				cmd.div_start = 1'b1;
				state_nxt     = pnlm_pkg::ST_DIV;
			end
			pnlm_pkg::ST_DIV: begin
				if (stat.div_done) begin
					state_nxt = pnlm_pkg::ST_WB;
				end
			end
			pnlm_pkg::ST_WB: begin
				cmd.wb    = 1'b1;
				state_nxt = pnlm_pkg::ST_TOT;
			end
			pnlm_pkg::ST_TOT: begin
				cmd.tot   = 1'b1;
				state_nxt = stat.ch_last ? pnlm_pkg::ST_NEXT : pnlm_pkg::ST_DGO;
			end
			pnlm_pkg::ST_NEXT: begin
				cmd.next_pix = 1'b1;
				state_nxt    = stat.img_last ? pnlm_pkg::ST_DONE : pnlm_pkg::ST_PIX;
			end
			pnlm_pkg::ST_DONE: begin
				if (!stat.out_full || out_ready) begin
					cmd.done_load = 1'b1;
					state_nxt     = pnlm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = pnlm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/pnlm_dp.sv
module pnlm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pnlm_pkg::cfg_t                cfg,
	input  pnlm_pkg::item_t               item_d,
	input  pnlm_pkg::cmd_t                cmd,
	input  logic                          out_ready,
	output pnlm_pkg::stat_t               stat,
	output logic                          out_valid,
	output logic                          out_kind,
	output logic [pnlm_pkg::PIX_W-1:0]    out_pixel,
	output logic [pnlm_pkg::TOT_W-1:0]    out_total
);

	localparam int NCH    = pnlm_pkg::MAX_CHANNELS;
	localparam int COL_W  = pnlm_pkg::COL_W;
	localparam int ROW_W  = pnlm_pkg::ROW_W;
	localparam int SITE_W = pnlm_pkg::SITE_W;
	localparam int CH_W   = pnlm_pkg::CH_W;
	localparam int DIM_W  = pnlm_pkg::DIM_W;
	localparam int PIX_W  = pnlm_pkg::PIX_W;
	localparam int CONF_W = pnlm_pkg::CONF_W;
	localparam int FLD_W  = pnlm_pkg::FLD_W;
	localparam int W_W    = pnlm_pkg::W_W;
	localparam int PROD_W = pnlm_pkg::PROD_W;
	localparam int WSUM_W = pnlm_pkg::WSUM_W;
	localparam int CSUM_W = pnlm_pkg::CSUM_W;
	localparam int NUM_W  = pnlm_pkg::NUM_W;
	localparam int SQ_W   = pnlm_pkg::SQ_W;
	localparam int TOT_W  = pnlm_pkg::TOT_W;
	localparam int WT_AW  = pnlm_pkg::WT_AW;
	localparam int SPAN_W = pnlm_pkg::SPAN_W;
	localparam int CX_W   = COL_W + 2;
	localparam int CY_W   = ROW_W + 2;

	// Input beat decode.
	logic              site_ok, ch_ok, wpos_ok;
	logic [SITE_W-1:0] site_in;
	logic              ld_pix, ld_fld, ld_mask, ld_wt, rd_issue, pass_init;
	logic [FLD_W-1:0]  fld_wdata;
	logic [CONF_W-1:0] conf_clip;
	logic [WT_AW-1:0]  wt_waddr;

	// Clearing sweep and readback.
	logic [SITE_W-1:0] clr_q;
	logic              rd_pend_q;
	logic [CH_W-1:0]   rd_ch_q;
	logic              rd_ok_q;

	// Output register.
	logic              out_valid_q;
	logic              out_kind_q;
	logic [PIX_W-1:0]  out_pix_q;
	logic [TOT_W-1:0]  out_tot_q;

	// Pass coordinates.
	logic [COL_W-1:0]  x_q, i_q, xa_q, xb_q;
	logic [ROW_W-1:0]  y_q, j_q, yb_q;
	logic [COL_W-1:0]  xa_c, xb_c;
	logic [ROW_W-1:0]  ya_c, yb_c;
	logic [DIM_W-1:0]  xs_c, ys_c, wm1, hm1;
	logic [SITE_W-1:0] site_xy, site_ij, site_c;

	// Contributor evaluation.
	logic [FLD_W-1:0]  fld_rd;
	logic [0:0]        dom_rd;
	logic [CONF_W-1:0] conf_rd;
	logic [PIX_W-1:0]  wt_rd;
	logic [CX_W-1:0]   cx_c;
	logic [CY_W-1:0]   cy_c;
	logic              cvalid_c, cvalid_q;
	logic [W_W:0]      wprod;
	logic [W_W-1:0]    weff, w_q;
	logic [DIM_W-1:0]  wrow_f, wcol_f;
	logic [WT_AW-1:0]  wt_raddr;

	// Pixel stores, one per channel.
	logic [NCH-1:0]    pix_we;
	logic [SITE_W-1:0] pix_waddr, pix_raddr;
	logic [PIX_W-1:0]  pix_wdata;
	logic              pix_re;
	logic [PIX_W-1:0]  pix_rd [NCH];

	// Sums and write-back.
	logic [PROD_W-1:0] prod_q [NCH];
	logic [CSUM_W-1:0] csum_q [NCH];
	logic [WSUM_W-1:0] wsum_q;
	logic [PIX_W-1:0]  pv_q [NCH];
	logic [CH_W-1:0]   ch_q;
	logic [NUM_W-1:0]  div_num;
	logic              div_done;
	logic [PIX_W-1:0]  quot;
	logic [PIX_W-1:0]  diff;
	logic [SQ_W-1:0]   sq_q;
	logic [TOT_W-1:0]  tot_q;
	logic [TOT_W:0]    tot_sum;

	always_comb begin
		site_ok   = ({1'b0, item_d.pos_x} < (COL_W+1)'(pnlm_pkg::MAX_WIDTH)) &&
		            ({1'b0, item_d.pos_y} < (ROW_W+1)'(pnlm_pkg::MAX_HEIGHT));
		ch_ok     = ({1'b0, item_d.channel} < (CH_W+1)'(NCH));
		wpos_ok   = ({1'b0, item_d.pos_x} < (COL_W+1)'(pnlm_pkg::PATCH_SPAN)) &&
		            ({1'b0, item_d.pos_y} < (ROW_W+1)'(pnlm_pkg::PATCH_SPAN));
		site_in   = {item_d.pos_y, item_d.pos_x};
		ld_pix    = cmd.accept && (item_d.command == pnlm_pkg::CMD_LOAD_PIX) && site_ok && ch_ok;
		ld_fld    = cmd.accept && (item_d.command == pnlm_pkg::CMD_LOAD_FIELD) && site_ok;
		ld_mask   = cmd.accept && (item_d.command == pnlm_pkg::CMD_LOAD_MASK) && site_ok;
		ld_wt     = cmd.accept && (item_d.command == pnlm_pkg::CMD_LOAD_WEIGHT) && wpos_ok;
		rd_issue  = cmd.accept && (item_d.command == pnlm_pkg::CMD_READ);
		pass_init = cmd.accept && (item_d.command == pnlm_pkg::CMD_START);
		// A negative match column is stored as no match.
		fld_wdata = item_d.field_x[6] ? '0 : {1'b1, item_d.field_y, item_d.field_x[5:0]};
		conf_clip = (item_d.confidence > CONF_W'(pnlm_pkg::CONF_ONE)) ?
		            CONF_W'(pnlm_pkg::CONF_ONE) : item_d.confidence;
		wt_waddr  = WT_AW'(item_d.pos_y[SPAN_W-1:0]) * WT_AW'(pnlm_pkg::PATCH_SPAN) +
		            WT_AW'(item_d.pos_x[SPAN_W-1:0]);
	end

	// Window bounds, clipped to the active image.
	always_comb begin
		wm1  = cfg.width - DIM_W'(1);
		hm1  = cfg.height - DIM_W'(1);
		xs_c = {1'b0, x_q} + DIM_W'(cfg.hpx);
		ys_c = {1'b0, y_q} + DIM_W'(cfg.hpy);
		xa_c = ({1'b0, x_q} < DIM_W'(cfg.hpx)) ? '0 : x_q - COL_W'(cfg.hpx);
		ya_c = ({1'b0, y_q} < DIM_W'(cfg.hpy)) ? '0 : y_q - ROW_W'(cfg.hpy);
		xb_c = (xs_c > wm1) ? wm1[COL_W-1:0] : xs_c[COL_W-1:0];
		yb_c = (ys_c > hm1) ? hm1[ROW_W-1:0] : ys_c[ROW_W-1:0];
		site_xy = {y_q, x_q};
		site_ij = {j_q, i_q};
	end

	// Weight position is taken relative to the window centre.
	always_comb begin
		wrow_f   = {1'b0, j_q} + DIM_W'(cfg.hpy) - {1'b0, y_q};
		wcol_f   = {1'b0, i_q} + DIM_W'(cfg.hpx) - {1'b0, x_q};
		wt_raddr = WT_AW'(wrow_f[SPAN_W-1:0]) * WT_AW'(pnlm_pkg::PATCH_SPAN) +
		           WT_AW'(wcol_f[SPAN_W-1:0]);
	end

	// Contributor: the match shifted by the offset of the window position.
	always_comb begin
		cx_c = CX_W'(fld_rd[COL_W-1:0]) + CX_W'(x_q) - CX_W'(i_q);
		cy_c = CY_W'(fld_rd[COL_W+ROW_W-1:COL_W]) + CY_W'(y_q) - CY_W'(j_q);
		cvalid_c = fld_rd[FLD_W-1] &&
		           !cx_c[CX_W-1] && (cx_c[CX_W-2:0] < cfg.width) &&
		           !cy_c[CY_W-1] && (cy_c[CY_W-2:0] < cfg.height);
		site_c = {cy_c[ROW_W-1:0], cx_c[COL_W-1:0]};
		wprod  = (W_W+1)'(wt_rd) * (W_W+1)'(conf_rd);
		weff   = (cfg.use_conf && dom_rd[0]) ? wprod[W_W-1:0] : {wt_rd, 16'b0};
	end

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			pix_we[c] = (ld_pix && (item_d.channel == CH_W'(c))) ||
			            (cmd.wb && (ch_q == CH_W'(c)));
		end
		pix_waddr = cmd.wb ? site_xy : site_in;
		pix_wdata = cmd.wb ? quot : item_d.pixel_in;
		pix_re    = rd_issue || cmd.win_eval || cmd.ctr_rd;
		pix_raddr = cmd.win_eval ? site_c : (cmd.ctr_rd ? site_xy : site_in);
	end

	for (genvar c = 0; c < NCH; c++) begin : g_pix
		pnlm_ram #(.WIDTH(PIX_W), .DEPTH(pnlm_pkg::SITES)) u_pix_ram (
			.clk   (clk),
			.we    (pix_we[c]),
			.waddr (pix_waddr),
			.wdata (pix_wdata),
			.re    (pix_re),
			.raddr (pix_raddr),
			.rdata (pix_rd[c])
		);
	end

	pnlm_ram #(.WIDTH(FLD_W), .DEPTH(pnlm_pkg::SITES)) u_fld_ram (
		.clk   (clk),
		.we    (cmd.clr || ld_fld),
		.waddr (cmd.clr ? clr_q : site_in),
		.wdata (cmd.clr ? '0 : fld_wdata),
		.re    (cmd.win_rd),
		.raddr (site_ij),
		.rdata (fld_rd)
	);

	pnlm_ram #(.WIDTH(1), .DEPTH(pnlm_pkg::SITES)) u_dom_ram (
		.clk   (clk),
		.we    (cmd.clr || ld_mask),
		.waddr (cmd.clr ? clr_q : site_in),
		.wdata (cmd.clr ? 1'b0 : item_d.in_domain),
		.re    (cmd.pix_rd || cmd.win_rd),
		.raddr (cmd.pix_rd ? site_xy : site_ij),
		.rdata (dom_rd)
	);

	pnlm_ram #(.WIDTH(CONF_W), .DEPTH(pnlm_pkg::SITES)) u_conf_ram (
		.clk   (clk),
		.we    (ld_mask),
		.waddr (site_in),
		.wdata (conf_clip),
		.re    (cmd.win_rd),
		.raddr (site_ij),
		.rdata (conf_rd)
	);

	pnlm_ram #(.WIDTH(PIX_W), .DEPTH(pnlm_pkg::WT_DEPTH)) u_wt_ram (
		.clk   (clk),
		.we    (ld_wt),
		.waddr (wt_waddr),
		.wdata (item_d.weight_in),
		.re    (cmd.win_rd),
		.raddr (wt_raddr),
		.rdata (wt_rd)
	);

	assign div_num = NUM_W'(csum_q[ch_q]) + NUM_W'(wsum_q >> 1);

	pnlm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (wsum_q),
		.done   (div_done),
		.quot   (quot)
	);

	assign diff    = (quot > pv_q[ch_q]) ? quot - pv_q[ch_q] : pv_q[ch_q] - quot;
	assign tot_sum = {1'b0, tot_q} + (TOT_W+1)'(sq_q);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + SITE_W'(1);
			end
			if (rd_issue) begin
				rd_pend_q <= 1'b1;
			end else if (cmd.rd_move) begin
				rd_pend_q <= 1'b0;
			end
			if (cmd.rd_move || cmd.done_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_ch_q <= item_d.channel;
			rd_ok_q <= site_ok && ch_ok;
		end
		if (cmd.rd_move) begin
			out_kind_q <= pnlm_pkg::RES_PIXEL;
			out_pix_q  <= rd_ok_q ? pix_rd[rd_ch_q] : '0;
			out_tot_q  <= '0;
		end else if (cmd.done_load) begin
			out_kind_q <= pnlm_pkg::RES_PASS;
			out_pix_q  <= '0;
			out_tot_q  <= tot_q;
		end

		if (pass_init) begin
			x_q   <= '0;
			y_q   <= '0;
			tot_q <= '0;
		end else if (cmd.next_pix) begin
			if ({1'b0, x_q} == wm1) begin
				x_q <= '0;
				y_q <= y_q + ROW_W'(1);
			end else begin
				x_q <= x_q + COL_W'(1);
			end
		end else if (cmd.tot) begin
			tot_q <= tot_sum[TOT_W] ? pnlm_pkg::TOT_MAX : tot_sum[TOT_W-1:0];
		end

		if (cmd.pix_eval) begin
			xa_q   <= xa_c;
			xb_q   <= xb_c;
			yb_q   <= yb_c;
			i_q    <= xa_c;
			j_q    <= ya_c;
			wsum_q <= '0;
			for (int c = 0; c < NCH; c++) begin
				csum_q[c] <= '0;
			end
		end else if (cmd.add) begin
			if (i_q == xb_q) begin
				i_q <= xa_q;
				j_q <= j_q + ROW_W'(1);
			end else begin
				i_q <= i_q + COL_W'(1);
			end
			if (cvalid_q) begin
				wsum_q <= wsum_q + WSUM_W'(w_q);
				for (int c = 0; c < NCH; c++) begin
					csum_q[c] <= csum_q[c] + CSUM_W'(prod_q[c]);
				end
			end
		end

		if (cmd.win_eval) begin
			cvalid_q <= cvalid_c;
			w_q      <= weff;
		end
		if (cmd.mul) begin
			for (int c = 0; c < NCH; c++) begin
				prod_q[c] <= PROD_W'(pix_rd[c]) * PROD_W'(w_q);
			end
		end
		if (cmd.ctr_eval) begin
			for (int c = 0; c < NCH; c++) begin
				pv_q[c] <= pix_rd[c];
			end
			ch_q <= '0;
		end else if (cmd.tot) begin
			ch_q <= ch_q + CH_W'(1);
		end
		if (cmd.wb) begin
			sq_q <= SQ_W'(diff) * SQ_W'(diff);
		end
	end

	always_comb begin
		stat.clr_last  = (clr_q == SITE_W'(pnlm_pkg::SITES - 1));
		stat.rd_pend   = rd_pend_q;
		stat.out_full  = out_valid_q;
		stat.dom_hit   = dom_rd[0];
		stat.win_last  = (i_q == xb_q) && (j_q == yb_q);
		stat.wsum_zero = (wsum_q == '0);
		stat.div_done  = div_done;
		stat.ch_last   = (ch_q == cfg.chans - CH_W'(1));
		stat.img_last  = ({1'b0, x_q} == wm1) && ({1'b0, y_q} == hm1);
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_pixel = out_pix_q;
	assign out_total = out_tot_q;

endmodule

### verif/tb_top.sv
import pnlm_pkg::*;

typedef struct {
	res_kind_t        kind;
	logic [15:0]      pixel;
	logic [TOT_W-1:0] change;
} inpaint_result_t;

class inpaint_board;
	localparam int PIXELS = SITES * MAX_CHANNELS;

	logic [15:0]       pix_mem [PIXELS];
	bit                pix_set [PIXELS];
	bit                fld_ok [SITES];
	int                fld_col [SITES];
	int                fld_row [SITES];
	bit                dom_mem [SITES];
	int unsigned       conf_mem [SITES];
	int unsigned       wt_mem [WT_DEPTH];
	int                width, height, chans, hpx, hpy;
	bit                use_conf;
	inpaint_result_t   pending[$];
	int                errors;

	function new();
		foreach (fld_ok[s]) begin
			fld_ok[s] = 0;
			dom_mem[s] = 0;
		end
		foreach (pix_set[p])
			pix_set[p] = 0;
		width = 64;
		height = 64;
		chans = 3;
		hpx = 2;
		hpy = 2;
		use_conf = 0;
		errors = 0;
	endfunction

	function int clampv(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function void set_reg(reg_idx_t idx, int unsigned v);
		case (idx)
			REG_WIDTH:    width = clampv(v & 'h7f, 1, MAX_WIDTH);
			REG_HEIGHT:   height = clampv(v & 'h7f, 1, MAX_HEIGHT);
			REG_CHANS:    chans = clampv(v & 'h3, 1, MAX_CHANNELS);
			REG_HPX:      hpx = clampv(v & 'h7, 0, MAX_HALF_PATCH);
			REG_HPY:      hpy = clampv(v & 'h7, 0, MAX_HALF_PATCH);
			REG_USE_CONF: use_conf = v[0];
			default: ;
		endcase
	endfunction

	// One full pass over the active image, updating pixels in place.
	function longint unsigned run_fill();
		longint unsigned total, wsum, w, nv, pv, d;
		longint unsigned csum [MAX_CHANNELS];
		int xa, xb, ya, yb, site, cx, cy, base;
		total = 0;
		for (int y = 0; y < height; y++) begin
			for (int x = 0; x < width; x++) begin
				if (!dom_mem[y*MAX_WIDTH+x])
					continue;
				xa = clampv(x - hpx, 0, width - 1);
				xb = clampv(x + hpx, 0, width - 1);
				ya = clampv(y - hpy, 0, height - 1);
				yb = clampv(y + hpy, 0, height - 1);
				wsum = 0;
				foreach (csum[c])
					csum[c] = 0;
				for (int j = ya; j <= yb; j++) begin
					for (int i = xa; i <= xb; i++) begin
						site = j*MAX_WIDTH + i;
						if (!fld_ok[site])
							continue;
						cx = fld_col[site] + x - i;
						cy = fld_row[site] + y - j;
						if (cx < 0 || cx >= width || cy < 0 || cy >= height)
							continue;
						w = wt_mem[(j-y+hpy)*PATCH_SPAN + (i-x+hpx)];
						if (use_conf && dom_mem[site])
							w = w * conf_mem[site];
						else
							w = w << 16;
						wsum += w;
						base = (cy*MAX_WIDTH + cx) * MAX_CHANNELS;
						for (int c = 0; c < chans; c++)
							csum[c] += longint'(pix_mem[base+c]) * w;
					end
				end
				if (wsum == 0)
					continue;
				base = (y*MAX_WIDTH + x) * MAX_CHANNELS;
				for (int c = 0; c < chans; c++) begin
					nv = (csum[c] + wsum/2) / wsum;
					pv = pix_mem[base+c];
					d = (nv > pv) ? nv - pv : pv - nv;
					total += d*d;
					if (total > TOT_MAX)
						total = TOT_MAX;
					pix_mem[base+c] = nv[15:0];
				end
			end
		end
		return total;
	endfunction

	function void note_beat(item_t it);
		inpaint_result_t r;
		int site, p;
		site = it.pos_y*MAX_WIDTH + it.pos_x;
		p = site*MAX_CHANNELS + it.channel;
		case (it.command)
			CMD_LOAD_PIX: if (it.channel < MAX_CHANNELS) begin
				pix_mem[p] = it.pixel_in;
				pix_set[p] = 1;
			end
			CMD_LOAD_FIELD: begin
				fld_ok[site] = !it.field_x[6];
				fld_col[site] = it.field_x[5:0];
				fld_row[site] = it.field_y;
			end
			CMD_LOAD_MASK: begin
				dom_mem[site] = it.in_domain;
				conf_mem[site] = (it.confidence > CONF_ONE) ? CONF_ONE : it.confidence;
			end
			CMD_LOAD_WEIGHT: if (it.pos_x < PATCH_SPAN && it.pos_y < PATCH_SPAN)
				wt_mem[it.pos_y*PATCH_SPAN + it.pos_x] = it.weight_in;
			CMD_START: begin
				r.kind = RES_PASS;
				r.pixel = 0;
				r.change = run_fill();
				pending.push_back(r);
			end
			CMD_READ: begin
				r.kind = RES_PIXEL;
				r.pixel = (it.channel < MAX_CHANNELS) ? pix_mem[p] : 16'd0;
				r.change = 0;
				pending.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function void check_beat(logic kind, logic [15:0] pixel, logic [TOT_W-1:0] change);
		inpaint_result_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result kind %0d pixel %h change %h",
				$time, kind, pixel, change);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (kind !== e.kind) begin
			$display("%0t: result_kind expected %0d actual %0d", $time, e.kind, kind);
			errors++;
		end
		if (pixel !== e.pixel) begin
			$display("%0t: pixel_out expected %h actual %h", $time, e.pixel, pixel);
			errors++;
		end
		if (change !== e.change) begin
			$display("%0t: total_change expected %h actual %h", $time, e.change, change);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int IDLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pnlm_item_if   item();
	pnlm_result_if result();

	patch_nlmeans_inpaint_update_core uut (
		.clk(clk), .arst_n(arst_n), .item(item.sink), .result(result.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	inpaint_board board = new();
	int beats_in = 0;
	int idle_cycles = 0;

	always #6 clk = ~clk;

	// Every input starts at a known value before reset is released.
	initial begin
		item.valid = 0;
		item.command = '0;
		item.pos_x = '0;
		item.pos_y = '0;
		item.channel = '0;
		item.pixel_in = '0;
		item.field_x = '0;
		item.field_y = '0;
		item.in_domain = 0;
		item.confidence = '0;
		item.weight_in = '0;
		result.ready = 0;
	end

	// Short gaps are the common case, with an occasional long one.
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Result side: random stalls, plus one long hold-off once traffic is flowing so that
	// the output register fills and the block pushes back on the item channel.
	initial begin
		int stall;
		bit held;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && beats_in >= 730) begin
				held = 1;
				result.ready <= 0;
				repeat (500) @(posedge clk);
			end
			stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			if (stall > 0) begin
				result.ready <= 0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1;
		end
	end

	// Result beats are checked on the same edge where they are taken.
	always @(posedge clk) begin
		if (result.valid && result.ready)
			board.check_beat(result.result_kind, result.pixel_out, result.total_change);
	end

	// A pass holds off the item side until it ends, so the watchdog only
	// fires after a long stretch with no beat on either channel.
	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("patch_nlmeans_inpaint_update_core regression: fail");
			$finish;
		end
	end

	// Drives one beat, waits for it to be taken, then maybe idles. Valid is only lowered
	// when a gap follows, so a back-to-back beat never sees two assignments in one step.
	task automatic send_item(item_t it, bit with_gap = 1);
		int g;
		item.valid <= 1;
		item.command <= it.command;
		item.pos_x <= it.pos_x;
		item.pos_y <= it.pos_y;
		item.channel <= it.channel;
		item.pixel_in <= it.pixel_in;
		item.field_x <= it.field_x;
		item.field_y <= it.field_y;
		item.in_domain <= it.in_domain;
		item.confidence <= it.confidence;
		item.weight_in <= it.weight_in;
		do
			@(posedge clk);
		while (!item.ready);
		board.note_beat(it);
		beats_in++;
		g = with_gap ? pick_gap() : 0;
		if (g > 0) begin
			item.valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic reg_write(reg_idx_t idx, int unsigned v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		board.set_reg(idx, v);
	endtask

	// Waits out every pending result plus a settling margin before registers change.
	task automatic drain();
		item.valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Random payload everywhere so unused fields toggle too.
	function item_t noise_item(cmd_code_t c);
		item_t it;
		it = item_t'($bits(item_t)'({$urandom, $urandom, $urandom}));
		it.command = c;
		return it;
	endfunction

	task automatic set_config(int w, int h, int ch, int px, int py, int uc);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_CHANS, ch);
		reg_write(REG_HPX, px);
		reg_write(REG_HPY, py);
		reg_write(REG_USE_CONF, uc);
	endtask

	// Every pixel channel in use and every mask entry of the active image is loaded so
	// that a pass never touches an entry that was never written.
	task automatic fill_image(int dom_pct);
		item_t it;
		for (int y = 0; y < board.height; y++) begin
			for (int x = 0; x < board.width; x++) begin
				for (int c = 0; c < board.chans; c++) begin
					it = noise_item(CMD_LOAD_PIX);
					it.pos_x = x;
					it.pos_y = y;
					it.channel = c;
					send_item(it, $urandom_range(0, 9) == 0);
				end
				it = noise_item(CMD_LOAD_MASK);
				it.pos_x = x;
				it.pos_y = y;
				it.in_domain = ($urandom_range(0, 99) < dom_pct);
				send_item(it, 0);
				it = noise_item(CMD_LOAD_FIELD);
				it.pos_x = x;
				it.pos_y = y;
				it.field_x[6] = ($urandom_range(0, 4) == 0);
				it.field_x[5:0] = $urandom_range(0, board.width - 1);
				it.field_y = $urandom_range(0, board.height - 1);
				send_item(it, 0);
			end
		end
	endtask

	// Mostly traffic inside the active image; reads only hit written entries or the
	// unused channel, which reads back as zero.
	function item_t random_item();
		item_t it;
		int r, p;
		r = $urandom_range(0, 999);
		if (r < 300)
			it = noise_item(CMD_LOAD_PIX);
		else if (r < 420)
			it = noise_item(CMD_LOAD_FIELD);
		else if (r < 540)
			it = noise_item(CMD_LOAD_MASK);
		else if (r < 610)
			it = noise_item(CMD_LOAD_WEIGHT);
		else if (r < 975)
			it = noise_item(CMD_READ);
		else if (r < 988)
			it = noise_item(CMD_START);
		else
			it = noise_item(cmd_code_t'($urandom_range(6, 7)));
		if ($urandom_range(0, 9) != 0) begin
			it.pos_x = $urandom_range(0, board.width - 1);
			it.pos_y = $urandom_range(0, board.height - 1);
			it.field_x[5:0] = $urandom_range(0, board.width - 1);
			it.field_y = $urandom_range(0, board.height - 1);
		end
		if (it.command == CMD_LOAD_WEIGHT && $urandom_range(0, 3) != 0) begin
			it.pos_x = $urandom_range(0, PATCH_SPAN - 1);
			it.pos_y = $urandom_range(0, PATCH_SPAN - 1);
		end
		if (it.command == CMD_READ) begin
			p = (it.pos_y*MAX_WIDTH + it.pos_x)*MAX_CHANNELS + it.channel;
			if (it.channel == 3 || !board.pix_set[p])
				it.channel = 3;
		end
		return it;
	endfunction

	initial begin
		item_t it;
		int budget;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		// The block clears its field and domain stores first; wait until it takes beats.
		do
			@(posedge clk);
		while (!item.ready);

		// Whole weight table first, with the extremes at the corners.
		for (int i = 0; i < WT_DEPTH; i++) begin
			it = noise_item(CMD_LOAD_WEIGHT);
			it.pos_x = i % PATCH_SPAN;
			it.pos_y = i / PATCH_SPAN;
			if (i == 0)
				it.weight_in = 16'hffff;
			else if (i == WT_DEPTH - 1)
				it.weight_in = 0;
			send_item(it, 0);
		end
		drain();
		set_config(4, 4, 1, 0, 0, 0);
		fill_image(60);

		// Directed: field extremes, pixel extremes, confidence clamping, ignored loads,
		// unused commands and the unused channel, then a pass and readback.
		it = noise_item(CMD_LOAD_PIX);
		it.pos_x = 0; it.pos_y = 0; it.channel = 0; it.pixel_in = 16'hffff;
		send_item(it);
		it.pos_x = 1; it.pixel_in = 0;
		send_item(it);
		it.pos_x = 63; it.pos_y = 63; it.channel = 3; it.pixel_in = 16'h1234;
		send_item(it);
		it = noise_item(CMD_LOAD_FIELD);
		it.pos_x = 1; it.pos_y = 1; it.field_x = -1; it.field_y = 0;
		send_item(it);
		it.pos_x = 2; it.field_x = -64;
		send_item(it);
		it.pos_x = 3; it.field_x = 63; it.field_y = 63;
		send_item(it);
		it.pos_x = 0; it.pos_y = 2; it.field_x = 0; it.field_y = 0;
		send_item(it);
		it = noise_item(CMD_LOAD_MASK);
		it.pos_x = 0; it.pos_y = 1; it.in_domain = 1; it.confidence = 17'h1ffff;
		send_item(it);
		it.pos_x = 1; it.confidence = CONF_ONE;
		send_item(it);
		it.pos_x = 2; it.confidence = 0;
		send_item(it);
		it = noise_item(CMD_LOAD_WEIGHT);
		it.pos_x = 9; it.pos_y = 0; it.weight_in = 16'h5555;
		send_item(it);
		it.pos_x = 0; it.pos_y = 63;
		send_item(it);
		it.pos_x = 8; it.pos_y = 8; it.weight_in = 16'hffff;
		send_item(it);
		send_item(noise_item(cmd_code_t'(3'd6)));
		send_item(noise_item(cmd_code_t'(3'd7)));
		it = noise_item(CMD_READ);
		it.pos_x = 0; it.pos_y = 0; it.channel = 0;
		send_item(it);
		it.channel = 3;
		send_item(it);
		send_item(noise_item(CMD_START));
		it = noise_item(CMD_READ);
		it.pos_x = 0; it.pos_y = 1; it.channel = 0;
		send_item(it);
		drain();
		set_config(4, 4, 1, 0, 0, 1);
		send_item(noise_item(CMD_START));
		drain();

		// Random phases over several settings, the extremes and clamped writes among them.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_config(1, 1, 3, 4, 4, 1);
				1: set_config(64, 1, 2, 4, 0, 0);
				2: set_config(2, 16, 1, 0, 4, 1);
				3: set_config(8, 8, 3, 4, 4, 1);
				4: set_config(0, 127, 0, 7, 7, 0);
				5: set_config(6, 5, 3, 1, 2, 0);
				default: set_config($urandom_range(1, 8), $urandom_range(1, 8),
					$urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7),
					$urandom_range(0, 1));
			endcase
			// The clamped setting gives a 1x64 image; the 8x8 phase gets a sparser domain.
			fill_image(ph == 3 ? 25 : 40);
			budget = 90;
			while (budget > 0) begin
				it = random_item();
				send_item(it);
				if (it.command <= CMD_READ)
					budget--;
			end
			send_item(noise_item(CMD_START));
			drain();
		end

		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("patch_nlmeans_inpaint_update_core regression: pass");
		else
			$display("patch_nlmeans_inpaint_update_core regression: fail");
		$finish;
	end
endmodule

### patch_nlmeans_inpaint_update_core.f
rtl/pnlm_pkg.sv
rtl/pnlm_if.sv
rtl/pnlm_ram.sv
rtl/pnlm_div.sv
rtl/pnlm_ctrl.sv
rtl/pnlm_dp.sv
rtl/patch_nlmeans_inpaint_update_core.sv
verif/tb_top.sv
